@@ hdl/ffha_pkg.sv @@
// Shared constants, types and helpers for the first-fit heap allocator.
// No dependencies.
`default_nettype none
package ffha_pkg;

   localparam int HEAP_BYTES     = 1024;
   localparam int GRANULE_BYTES  = 16;
   localparam int NUM_GRAN       = HEAP_BYTES / GRANULE_BYTES;
   localparam int GRAN_W         = $clog2(NUM_GRAN);
   localparam int GSH            = $clog2(GRANULE_BYTES);
   localparam int ADDR_W         = 10;
   localparam int REQ_W          = 10;
   localparam int NEED_W         = REQ_W + 1 - GSH;
   localparam int SPLIT_MIN_GRAN = 3;
   localparam int CMP_W          = ((GRAN_W + 1 > ADDR_W) ? GRAN_W + 1 : ADDR_W) + 2;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic              head;
      logic              used;
      logic [GRAN_W-1:0] size;
   } entry_type;

   typedef struct packed {
      logic              rd_en;
      logic [GRAN_W-1:0] rd_addr;
      logic              wr_en;
      logic [GRAN_W-1:0] wr_addr;
      entry_type         wr_data;
   } tbl_cmd_type;

   // value of an entry that has not been written since reset
   function automatic entry_type reset_entry(input logic [GRAN_W-1:0] idx);
      entry_type e;
      e = '0;
      if (idx == '0) begin
         e.head = 1'b1;
         e.size = GRAN_W'(NUM_GRAN - 1);
      end
      return e;
   endfunction

endpackage
`default_nettype wire

@@ hdl/ffha_chan_if.sv @@
// Valid/ready channel interfaces for allocator command and result items.
// Depends on ffha_pkg.
`default_nettype none
interface ffha_req_if;
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic [ffha_pkg::REQ_W-1:0]   request_size;
   logic [ffha_pkg::ADDR_W-1:0]  free_address;

   modport source (output valid, command, request_size, free_address, input ready);
   modport sink   (input valid, command, request_size, free_address, output ready);
endinterface

interface ffha_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         ok;
   logic [ffha_pkg::ADDR_W-1:0]  data_address;

   modport source (output valid, ok, data_address, input ready);
   modport sink   (input valid, ok, data_address, output ready);
endinterface
`default_nettype wire

@@ hdl/ffha_table.sv @@
// Block table memory: one entry per granule, one read and one write port,
// registered read data. Unwritten entries read as their reset value.
// Depends on ffha_pkg.
`default_nettype none
module ffha_table (
   input  wire                     clock,
   input  wire                     reset,
   input  ffha_pkg::tbl_cmd_type   cmd,
   output ffha_pkg::entry_type     rd_data
);

   ffha_pkg::entry_type                 table_mem [ffha_pkg::NUM_GRAN];
   logic [ffha_pkg::NUM_GRAN-1:0]       valid_ff;
   logic [ffha_pkg::NUM_GRAN-1:0]       valid_in;
   ffha_pkg::entry_type                 rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.wr_en) begin
         valid_in[cmd.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         table_mem[cmd.wr_addr] <= cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= valid_ff[cmd.rd_addr] ? table_mem[cmd.rd_addr]
                                             : ffha_pkg::reset_entry(cmd.rd_addr);
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ hdl/ffha_ctrl.sv @@
// Command sequencer: walks the block list in the table, allocates with
// split, frees with coalescing, and holds the result item register.
// Depends on ffha_pkg and ffha_chan_if.
`default_nettype none
module ffha_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   ffha_req_if.sink                req_ch,
   ffha_rsp_if.source              rsp_ch,
   output ffha_pkg::tbl_cmd_type   tbl_cmd,
   input  ffha_pkg::entry_type     rd_data
);

   localparam int GW = ffha_pkg::GRAN_W;
   localparam int CW = ffha_pkg::CMP_W;
   localparam int NW = ffha_pkg::NEED_W;
   localparam int AW = ffha_pkg::ADDR_W;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_A_RD    = 4'd1;
   localparam logic [3:0] S_A_CHK   = 4'd2;
   localparam logic [3:0] S_A_SPLIT = 4'd3;
   localparam logic [3:0] S_F_RD    = 4'd4;
   localparam logic [3:0] S_F_CHK   = 4'd5;
   localparam logic [3:0] S_C_RD    = 4'd6;
   localparam logic [3:0] S_C_G     = 4'd7;
   localparam logic [3:0] S_C_NRD   = 4'd8;
   localparam logic [3:0] S_C_N     = 4'd9;
   localparam logic [3:0] S_C_CLR   = 4'd10;
   localparam logic [3:0] S_DONE    = 4'd11;

   logic [3:0]            state_ff,     state_in;
   logic [GW-1:0]         g_ff,         g_in;
   logic [GW-1:0]         n_ff,         n_in;
   ffha_pkg::entry_type   cur_ff,       cur_in;
   logic [NW-1:0]         need_ff,      need_in;
   logic [GW-1:0]         ng_ff,        ng_in;
   logic [GW-1:0]         rem_ff,       rem_in;
   logic                  ok_ff,        ok_in;
   logic [AW-1:0]         data_ff,      data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff,    rsp_ok_in;
   logic [AW-1:0]         rsp_data_ff,  rsp_data_in;

   logic                  req_fire;
   logic [CW-1:0]         g_w, size_w, need_w, next_w, ng_w, cnext_w;
   logic [CW-1:0]         addr_w, gf_w;
   logic                  fit, split_ok;
   ffha_pkg::entry_type   merged;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.ok           = rsp_ok_ff;
   assign rsp_ch.data_address = rsp_data_ff;

   assign g_w      = CW'(g_ff);
   assign size_w   = CW'(rd_data.size);
   assign need_w   = CW'(need_ff);
   assign next_w   = g_w + CW'(1) + size_w;
   assign ng_w     = g_w + CW'(1) + need_w;
   assign cnext_w  = g_w + CW'(1) + CW'(cur_ff.size);
   assign fit      = !rd_data.used && (size_w >= need_w);
   assign split_ok = (size_w >= need_w + CW'(1 + ffha_pkg::SPLIT_MIN_GRAN))
                     && (ng_w < CW'(ffha_pkg::NUM_GRAN));
   assign addr_w   = CW'(req_ch.free_address);
   assign gf_w     = (addr_w >> ffha_pkg::GSH) - CW'(1);

   always_comb begin
      merged      = cur_ff;
      merged.size = GW'(CW'(cur_ff.size) + CW'(1) + size_w);
   end

   always_comb begin
      state_in     = state_ff;
      g_in         = g_ff;
      n_in         = n_ff;
      cur_in       = cur_ff;
      need_in      = need_ff;
      ng_in        = ng_ff;
      rem_in       = rem_ff;
      ok_in        = ok_ff;
      data_in      = data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_data_in  = rsp_data_ff;
      tbl_cmd      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               ok_in   = 1'b0;
               data_in = '0;
               if (req_ch.command == ffha_pkg::CMD_ALLOC) begin
                  need_in  = NW'((CW'(req_ch.request_size)
                                 + CW'(ffha_pkg::GRANULE_BYTES - 1)) >> ffha_pkg::GSH);
                  g_in     = '0;
                  state_in = S_A_RD;
               end else if ((req_ch.free_address[ffha_pkg::GSH-1:0] == '0)
                            && (addr_w >= CW'(ffha_pkg::GRANULE_BYTES))
                            && (gf_w < CW'(ffha_pkg::NUM_GRAN))) begin
                  g_in     = gf_w[GW-1:0];
                  state_in = S_F_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_A_RD: begin
            tbl_cmd.rd_en   = 1'b1;
            tbl_cmd.rd_addr = g_ff;
            state_in        = S_A_CHK;
         end
         S_A_CHK: begin
            if (!rd_data.head) begin
               state_in = S_DONE;
            end else if (fit) begin
               tbl_cmd.wr_en        = 1'b1;
               tbl_cmd.wr_addr      = g_ff;
               tbl_cmd.wr_data      = rd_data;
               tbl_cmd.wr_data.used = 1'b1;
               if (split_ok) begin
                  tbl_cmd.wr_data.size = GW'(need_w);
               end
               ok_in    = 1'b1;
               data_in  = AW'((g_w + CW'(1)) << ffha_pkg::GSH);
               ng_in    = ng_w[GW-1:0];
               rem_in   = GW'(size_w - need_w - CW'(1));
               state_in = split_ok ? S_A_SPLIT : S_DONE;
            end else if (next_w >= CW'(ffha_pkg::NUM_GRAN)) begin
               state_in = S_DONE;
            end else begin
               g_in     = next_w[GW-1:0];
               state_in = S_A_RD;
            end
         end
         S_A_SPLIT: begin
            tbl_cmd.wr_en        = 1'b1;
            tbl_cmd.wr_addr      = ng_ff;
            tbl_cmd.wr_data.head = 1'b1;
            tbl_cmd.wr_data.used = 1'b0;
            tbl_cmd.wr_data.size = rem_ff;
            state_in             = S_DONE;
         end
         S_F_RD: begin
            tbl_cmd.rd_en   = 1'b1;
            tbl_cmd.rd_addr = g_ff;
            state_in        = S_F_CHK;
         end
         S_F_CHK: begin
            if (rd_data.head && rd_data.used) begin
               tbl_cmd.wr_en        = 1'b1;
               tbl_cmd.wr_addr      = g_ff;
               tbl_cmd.wr_data      = rd_data;
               tbl_cmd.wr_data.used = 1'b0;
               ok_in                = 1'b1;
               g_in                 = '0;
               state_in             = S_C_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_C_RD: begin
            tbl_cmd.rd_en   = 1'b1;
            tbl_cmd.rd_addr = g_ff;
            state_in        = S_C_G;
         end
         S_C_G: begin
            cur_in   = rd_data;
            state_in = rd_data.head ? S_C_NRD : S_DONE;
         end
         S_C_NRD: begin
            if (cnext_w >= CW'(ffha_pkg::NUM_GRAN)) begin
               state_in = S_DONE;
            end else begin
               tbl_cmd.rd_en   = 1'b1;
               tbl_cmd.rd_addr = cnext_w[GW-1:0];
               n_in            = cnext_w[GW-1:0];
               state_in        = S_C_N;
            end
         end
         S_C_N: begin
            if (!rd_data.head) begin
               state_in = S_DONE;
            end else if (!cur_ff.used && !rd_data.used) begin
               tbl_cmd.wr_en   = 1'b1;
               tbl_cmd.wr_addr = g_ff;
               tbl_cmd.wr_data = merged;
               cur_in          = merged;
               state_in        = S_C_CLR;
            end else begin
               g_in     = n_ff;
               cur_in   = rd_data;
               state_in = S_C_NRD;
            end
         end
         S_C_CLR: begin
            tbl_cmd.wr_en   = 1'b1;
            tbl_cmd.wr_addr = n_ff;
            tbl_cmd.wr_data = '0;
            state_in        = S_C_NRD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_data_in  = data_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      g_ff        <= g_in;
      n_ff        <= n_in;
      cur_ff      <= cur_in;
      need_ff     <= need_in;
      ng_ff       <= ng_in;
      rem_ff      <= rem_in;
      ok_ff       <= ok_in;
      data_ff     <= data_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_idle_no_access: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!tbl_cmd.rd_en && !tbl_cmd.wr_en))
      else $error("table accessed while idle");

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (tbl_cmd.rd_en && tbl_cmd.wr_en) |-> (tbl_cmd.rd_addr != tbl_cmd.wr_addr))
      else $error("read and write of the same entry in one cycle");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_data_ff == '0))
      else $error("failed item carries an address");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside completion");

endmodule
`default_nettype wire

@@ hdl/first_fit_heap_allocator.sv @@
// First-fit heap allocator over a 1024-byte heap in 16-byte granules, one header
// granule per block. One command item is taken at a time and gives one result item.
// The block list lives in a 64-entry table memory with registered read data;
// each header visited is read, then checked. An allocate walks the list from the
// start to the first fit and may then write a split remainder; a free walks the
// list from the start after marking its block free, merging free neighbours, and a
// walk visits at most 64 headers. The table comes out of reset ready; no clearing pass is needed.
// Depends on ffha_pkg, ffha_chan_if, ffha_table and ffha_ctrl.
`default_nettype none
module first_fit_heap_allocator (
   input  wire          clock,
   input  wire          reset,
   ffha_req_if.sink     req_ch,
   ffha_rsp_if.source   rsp_ch
);

   ffha_pkg::tbl_cmd_type  tbl_cmd;
   ffha_pkg::entry_type    rd_data;

   ffha_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .tbl_cmd (tbl_cmd),
      .rd_data (rd_data)
   );

   ffha_table u_table (
      .clock   (clock),
      .reset   (reset),
      .cmd     (tbl_cmd),
      .rd_data (rd_data)
   );

endmodule
`default_nettype wire
